// ===== rtl/dlle_pkg.sv =====
// Shared types and constants for the doubly linked list engine.
`default_nettype none

package dlle_pkg;

    localparam int OP_W     = 3;
    localparam int NODE_W   = 11;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Operation codes; codes 6 and 7 are no-ops.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_LEFT   = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_RIGHT  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_STEP  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_END  = 2'd3;

    // Sentinel slots.
    localparam int SLOT_HEAD = 0;
    localparam int SLOT_TAIL = 1;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [NODE_W-1:0]         node_number;
        logic signed [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic                      is_last;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/dlle_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module dlle_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/doubly_linked_list_engine.sv =====
// Linked list engine: four RAMs (left, right, value, dead) and the op sequencer.
// Sequence, accept to result: inserts pass EXEC (link read data, node write) and LINK (neighbor
// link write); a read step that reaches a node passes EXEC and READ2; delete, refused ops and the
// read step at the list end finish in EXEC. One item is in flight; the next beat is taken in IDLE.
// A result waiting in the output register does not hold off the next beat; a second one does.
// Reset is synchronous; the init state then seeds the sentinel links, and no beat is taken in it.
`default_nettype none

module doubly_linked_list_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dlle_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dlle_pkg::t_out_beat  o_out_beat
);

    import dlle_pkg::*;

    localparam int SLOTS  = CAPACITY + 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KW     = ((NODE_W > CNT_W) ? NODE_W : CNT_W) + 1;

    localparam logic [SLOT_W-1:0] HEAD_S = SLOT_W'(SLOT_HEAD);
    localparam logic [SLOT_W-1:0] TAIL_S = SLOT_W'(SLOT_TAIL);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_LINK  = 6'b001000,
        S_READ2 = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Item registers captured at accept.
    logic [OP_W-1:0]           r_op, n_op;
    logic [SLOT_W-1:0]         r_node_slot, n_node_slot;
    logic                      r_node_ok, n_node_ok;
    logic signed [VALUE_W-1:0] r_value, n_value;

    // Persistent list state outside the RAMs.
    logic [CNT_W-1:0]  r_free, n_free;
    logic [SLOT_W-1:0] r_cursor, n_cursor;

    // Insert bookkeeping for the second write cycle.
    logic [SLOT_W-1:0] r_at, n_at;
    logic [SLOT_W-1:0] r_nb, n_nb;
    logic [SLOT_W-1:0] r_new, n_new;

    // Result waiting for a free output register, and the output register itself.
    t_out_beat r_res, n_res;
    t_out_beat r_out, n_out;
    logic      r_out_valid, n_out_valid;

    // RAM ports: left links, right links, values, dead flags.
    logic              lm_we, rm_we, vm_we, dm_we;
    logic [SLOT_W-1:0] lm_waddr, rm_waddr, vm_waddr, dm_waddr;
    logic [SLOT_W-1:0] lm_wdata, rm_wdata;
    logic [VALUE_W-1:0] vm_wdata;
    logic [0:0]        dm_wdata;
    logic [SLOT_W-1:0] lm_raddr, rm_raddr, vm_raddr, dm_raddr;
    logic [SLOT_W-1:0] lm_rdata, rm_rdata;
    logic [VALUE_W-1:0] vm_rdata;
    logic [0:0]        dm_rdata;

    // Accept-side decode of the node number.
    logic [KW-1:0]     k_ext;
    logic [SLOT_W-1:0] s_in;
    logic              node_ok_in;

    logic      accept;
    logic      out_free;
    logic      fin;
    t_out_beat fin_res;
    logic      do_ins;
    logic [SLOT_W-1:0] ins_at, ins_nb;
    logic      bad;
    logic      full;

    dlle_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_left (
        .i_clk   (i_clk),
        .i_we    (lm_we),
        .i_waddr (lm_waddr),
        .i_wdata (lm_wdata),
        .i_raddr (lm_raddr),
        .o_rdata (lm_rdata)
    );

    dlle_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_right (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_raddr (rm_raddr),
        .o_rdata (rm_rdata)
    );

    dlle_ram #(.DEPTH(SLOTS), .WIDTH(VALUE_W)) u_value (
        .i_clk   (i_clk),
        .i_we    (vm_we),
        .i_waddr (vm_waddr),
        .i_wdata (vm_wdata),
        .i_raddr (vm_raddr),
        .o_rdata (vm_rdata)
    );

    // Dead flag is written on insert (clear) and delete (set); a slot below the fill
    // count, sentinel slots aside, always has a written flag, so no clearing pass is needed.
    dlle_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_dead (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Node k sits in slot k+1; it is nameable when in range and already allocated.
    assign k_ext      = KW'(i_in_beat.node_number);
    assign s_in       = SLOT_W'(k_ext + KW'(1));
    assign node_ok_in = (k_ext != '0) && (k_ext <= KW'(CAPACITY))
                        && ((k_ext + KW'(1)) < KW'(r_free));

    assign bad  = !r_node_ok || dm_rdata[0];
    assign full = (r_free >= CNT_W'(SLOTS));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_node_slot = r_node_slot;
        n_node_ok   = r_node_ok;
        n_value     = r_value;
        n_free      = r_free;
        n_cursor    = r_cursor;
        n_at        = r_at;
        n_nb        = r_nb;
        n_new       = r_new;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0;
        rm_we = 1'b0; rm_waddr = '0; rm_wdata = '0;
        vm_we = 1'b0; vm_waddr = '0; vm_wdata = '0;
        dm_we = 1'b0; dm_waddr = '0; dm_wdata = '0;

        // Read addresses: issued from the incoming beat at accept, from the fetched
        // successor during the read step's second access.
        lm_raddr = (i_in_beat.operation == OP_PUSH_BACK) ? TAIL_S : s_in;
        dm_raddr = s_in;
        if (r_state == S_EXEC) begin
            rm_raddr = rm_rdata;
        end else if (i_in_beat.operation == OP_PUSH_FRONT) begin
            rm_raddr = HEAD_S;
        end else if (i_in_beat.operation == OP_READ_STEP) begin
            rm_raddr = r_cursor;
        end else begin
            rm_raddr = s_in;
        end
        vm_raddr = rm_rdata;

        fin     = 1'b0;
        fin_res = '{status: ST_OK, read_value: '0, is_last: 1'b0};
        do_ins  = 1'b0;
        ins_at  = HEAD_S;
        ins_nb  = rm_rdata;

        unique case (r_state)
            S_INIT: begin
                // Seed the sentinels: head points right to tail, tail left to head.
                rm_we    = 1'b1;
                rm_waddr = HEAD_S;
                rm_wdata = TAIL_S;
                lm_we    = 1'b1;
                lm_waddr = TAIL_S;
                lm_wdata = HEAD_S;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_op        = i_in_beat.operation;
                    n_node_slot = s_in;
                    n_node_ok   = node_ok_in;
                    n_value     = i_in_beat.value;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_PUSH_FRONT: begin
                        do_ins = 1'b1;
                        ins_at = HEAD_S;
                        ins_nb = rm_rdata;
                    end
                    OP_PUSH_BACK: begin
                        do_ins = 1'b1;
                        ins_at = lm_rdata;
                        ins_nb = TAIL_S;
                    end
                    OP_INS_LEFT: begin
                        if (bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_BAD;
                        end else begin
                            do_ins = 1'b1;
                            ins_at = lm_rdata;
                            ins_nb = r_node_slot;
                        end
                    end
                    OP_INS_RIGHT: begin
                        if (bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_BAD;
                        end else begin
                            do_ins = 1'b1;
                            ins_at = r_node_slot;
                            ins_nb = rm_rdata;
                        end
                    end
                    OP_DELETE: begin
                        fin = 1'b1;
                        if (bad) begin
                            fin_res.status = ST_BAD;
                        end else begin
                            // Unlink: left neighbor skips right, right skips left.
                            rm_we    = 1'b1;
                            rm_waddr = lm_rdata;
                            rm_wdata = rm_rdata;
                            lm_we    = 1'b1;
                            lm_waddr = rm_rdata;
                            lm_wdata = lm_rdata;
                            dm_we    = 1'b1;
                            dm_waddr = r_node_slot;
                            dm_wdata = 1'b1;
                            // Step the cursor back so the walk resumes past the hole.
                            if (r_cursor == r_node_slot) begin
                                n_cursor = lm_rdata;
                            end
                        end
                    end
                    OP_READ_STEP: begin
                        if ((rm_rdata == TAIL_S)
                            || (CNT_W'(rm_rdata) >= CNT_W'(SLOTS))) begin
                            fin            = 1'b1;
                            fin_res.status = ST_END;
                            n_cursor       = HEAD_S;
                        end else begin
                            // Value and successor of the new node are read this cycle.
                            n_cursor = rm_rdata;
                            n_state  = S_READ2;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase

                if (do_ins) begin
                    if (full) begin
                        fin            = 1'b1;
                        fin_res.status = ST_FULL;
                    end else begin
                        // Write the new node; neighbor links follow next cycle.
                        vm_we    = 1'b1;
                        vm_waddr = SLOT_W'(r_free);
                        vm_wdata = r_value;
                        lm_we    = 1'b1;
                        lm_waddr = SLOT_W'(r_free);
                        lm_wdata = ins_at;
                        rm_we    = 1'b1;
                        rm_waddr = SLOT_W'(r_free);
                        rm_wdata = ins_nb;
                        dm_we    = 1'b1;
                        dm_waddr = SLOT_W'(r_free);
                        dm_wdata = 1'b0;
                        n_at     = ins_at;
                        n_nb     = ins_nb;
                        n_new    = SLOT_W'(r_free);
                        n_free   = r_free + CNT_W'(1);
                        n_state  = S_LINK;
                    end
                end
            end
            S_LINK: begin
                lm_we    = 1'b1;
                lm_waddr = r_nb;
                lm_wdata = r_new;
                rm_we    = 1'b1;
                rm_waddr = r_at;
                rm_wdata = r_new;
                fin      = 1'b1;
            end
            S_READ2: begin
                fin                = 1'b1;
                fin_res.read_value = vm_rdata;
                fin_res.is_last    = (rm_rdata == TAIL_S);
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it until that frees up.
        if (fin) begin
            if (out_free) begin
                n_out       = fin_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_free      <= CNT_W'(2);
            r_cursor    <= HEAD_S;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_node_slot <= n_node_slot;
        r_node_ok   <= n_node_ok;
        r_value     <= n_value;
        r_at        <= n_at;
        r_nb        <= n_nb;
        r_new       <= n_new;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire
